// ----- rtl/core/atte_pkg.sv -----
// shared types, constants and helpers of the ansi text terminal engine
package atte_pkg;

    localparam int MaxParamsDefault = 3;
    localparam logic [7:0] ColumnsReset = 8'd80;
    localparam logic [7:0] RowsReset = 8'd25;
    localparam logic [23:0] ForeReset = 24'hC0C0C0;
    localparam logic [23:0] BackReset = 24'h000000;

    localparam logic [2:0] KindPut = 3'd0;
    localparam logic [2:0] KindClear = 3'd1;
    localparam logic [2:0] KindClearEol = 3'd2;
    localparam logic [2:0] KindScroll = 3'd3;
    localparam logic [2:0] KindReport = 3'd4;

    localparam logic [0:0] RegColumns = 1'b0;
    localparam logic [0:0] RegRows = 1'b1;

    localparam logic [15:0] ChEsc = 16'd27;
    localparam logic [15:0] ChTab = 16'd9;
    localparam logic [15:0] ChLf = 16'd10;
    localparam logic [15:0] ChCr = 16'd13;
    localparam logic [15:0] ChBs = 16'd8;
    localparam logic [15:0] ChBracket = 16'd91;
    localparam logic [15:0] ChSemi = 16'd59;
    localparam logic [15:0] ChZero = 16'd48;
    localparam logic [15:0] ChNine = 16'd57;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2,
        PH_CSI3 = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SGR,
        ST_WRAP,
        ST_EMIT
    } t_state;

    // one result
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  column;
        logic [7:0]  row;
        logic [15:0] glyph;
        logic [23:0] fore_rgb;
        logic [23:0] back_rgb;
        logic [7:0]  scroll_lines;
        logic        last;
    } t_event;

    // sgr unit result
    typedef struct packed {
        logic [23:0] cur_fore;
        logic [23:0] cur_back;
        logic [23:0] dflt_fore;
        logic [23:0] dflt_back;
    } t_colours;

    function automatic logic [23:0] palette(input logic [2:0] idx);
        logic [23:0] c;
        case (idx)
            3'd0: c = 24'h000000;
            3'd1: c = 24'h800000;
            3'd2: c = 24'h008000;
            3'd3: c = 24'h808000;
            3'd4: c = 24'h000080;
            3'd5: c = 24'h800080;
            3'd6: c = 24'h008080;
            default: c = 24'hC0C0C0;
        endcase
        return c;
    endfunction

    function automatic logic [23:0] brighter(input logic [23:0] c);
        return {c[23] ? 8'hFF : 8'h80, c[15] ? 8'hFF : 8'h80, c[7] ? 8'hFF : 8'h80};
    endfunction

endpackage

// ----- rtl/core/atte_if.sv -----
// handshake channel interfaces
interface atte_char_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface atte_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [15:0] glyph;
    logic [23:0] fore_rgb;
    logic [23:0] back_rgb;
    logic [7:0]  scroll_lines;
    logic        last;
    modport source (output valid, output kind, output column, output row, output glyph,
                    output fore_rgb, output back_rgb, output scroll_lines, output last,
                    input ready);
    modport sink (input valid, input kind, input column, input row, input glyph,
                  input fore_rgb, input back_rgb, input scroll_lines, input last,
                  output ready);
endinterface

interface atte_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/ansi_text_terminal_engine.sv -----
// top level of the ansi text terminal engine
// Character codes enter on i_char (valid/ready), one item at a time. Results
// leave on o_event; an item gives zero, one or two results, the final one
// flagged by last. Configuration writes (index 0 columns, index 1 rows) come
// on i_cfg and are taken while the block is idle; a character offered in the
// same cycle waits. The cursor is clamped to the new size. Each item is
// handled by a small sequencer: a decode state, then for an sgr command one
// stored parameter per cycle through the shared colour unit, then a wrap and
// scroll state, then each result in turn from the output register. Ready
// stays low until the last result of the item has been taken, so a stalled
// receiver holds the block.
// After reset the cursor sits at the top left, colours are light grey on
// black, the parser is in text mode and the screen is 80 by 25.
module ansi_text_terminal_engine #(
    parameter int MAX_PARAMS = atte_pkg::MaxParamsDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    atte_char_if.sink    i_char,
    atte_cfg_if.sink     i_cfg,
    atte_event_if.source o_event
);
    import atte_pkg::*;

    localparam int PiW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [PiW-1:0] r_pidx, n_pidx;
    logic [15:0] r_param [MAX_PARAMS];
    logic [15:0] n_param [MAX_PARAMS];
    logic [8:0]  r_col, n_col;
    logic [16:0] r_row, n_row;
    logic [7:0]  r_scol, n_scol, r_srow, n_srow;
    t_colours    r_colr, n_colr;
    logic [7:0]  r_cols, r_rows;
    logic [15:0] r_char, n_char;
    logic [PiW-1:0] r_sgr_i, n_sgr_i;
    logic [PiW-1:0] r_sgr_n, n_sgr_n;
    t_event      r_ev [2];
    t_event      n_ev [2];
    logic [1:0]  r_nev, n_nev;
    logic        r_eidx, n_eidx;

    logic [7:0]  w_w, w_h;
    t_colours    w_sgr_out;
    t_event      w_ev;

    assign w_w = (r_cols == 8'd0) ? 8'd1 : r_cols;
    assign w_h = (r_rows == 8'd0) ? 8'd1 : r_rows;

    atte_sgr_unit u_sgr (
        .i_value (r_param[r_sgr_i]),
        .i_col   (r_colr),
        .o_col   (w_sgr_out)
    );

    assign i_char.ready = (r_state == ST_IDLE) && !i_cfg.valid;
    assign i_cfg.ready = (r_state == ST_IDLE);
    assign o_event.valid = (r_state == ST_EMIT);
    assign w_ev = r_ev[r_eidx];
    assign o_event.kind = w_ev.kind;
    assign o_event.column = w_ev.column;
    assign o_event.row = w_ev.row;
    assign o_event.glyph = w_ev.glyph;
    assign o_event.fore_rgb = w_ev.fore_rgb;
    assign o_event.back_rgb = w_ev.back_rgb;
    assign o_event.scroll_lines = w_ev.scroll_lines;
    assign o_event.last = (r_eidx == 1'b1) || (r_nev == 2'd1);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_TEXT;
            r_pidx  <= '0;
            for (int k = 0; k < MAX_PARAMS; k++) r_param[k] <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_scol  <= '0;
            r_srow  <= '0;
            r_colr  <= '{ForeReset, BackReset, ForeReset, BackReset};
            r_nev   <= '0;
            r_eidx  <= 1'b0;
            r_sgr_i <= '0;
            r_sgr_n <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_pidx  <= n_pidx;
            r_param <= n_param;
            r_col   <= n_col;
            r_row   <= n_row;
            r_scol  <= n_scol;
            r_srow  <= n_srow;
            r_colr  <= n_colr;
            r_nev   <= n_nev;
            r_eidx  <= n_eidx;
            r_sgr_i <= n_sgr_i;
            r_sgr_n <= n_sgr_n;
        end
    end

    // screen size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= ColumnsReset;
            r_rows <= RowsReset;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.index == RegColumns) r_cols <= i_cfg.data;
            else r_rows <= i_cfg.data;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_ev   <= n_ev;
    end

    // sequencer
    always_comb begin
        logic [15:0] v_c;
        logic [15:0] v_p0, v_p1, v_dig;
        logic [19:0] v_acc;
        logic [PiW-1:0] v_pi;
        logic [16:0] v_lines;
        logic [16:0] v_csum;
        logic [8:0]  v_tab;
        t_event      v_e;
        logic [7:0]  v_wc, v_hc;
        n_state = r_state;
        n_phase = r_phase;
        n_pidx  = r_pidx;
        n_param = r_param;
        n_col   = r_col;
        n_row   = r_row;
        n_scol  = r_scol;
        n_srow  = r_srow;
        n_colr  = r_colr;
        n_char  = r_char;
        n_ev    = r_ev;
        n_nev   = r_nev;
        n_eidx  = r_eidx;
        n_sgr_i = r_sgr_i;
        n_sgr_n = r_sgr_n;
        v_c     = r_char;
        v_p0    = r_param[0];
        v_p1    = r_param[(MAX_PARAMS > 1) ? 1 : 0];
        v_dig   = v_c - ChZero;
        v_acc   = '0;
        v_pi    = r_pidx;
        v_lines = '0;
        v_csum  = '0;
        v_tab   = '0;
        v_e     = '0;
        v_wc    = w_w - 8'd1;
        v_hc    = w_h - 8'd1;
        unique case (r_state)
            ST_IDLE: begin
                n_nev = 2'd0;
                n_eidx = 1'b0;
                if (i_cfg.valid) begin
                    // clamp cursor to new size
                    if (i_cfg.index == RegColumns) begin
                        v_wc = (i_cfg.data == 8'd0) ? 8'd0 : i_cfg.data - 8'd1;
                    end else begin
                        v_hc = (i_cfg.data == 8'd0) ? 8'd0 : i_cfg.data - 8'd1;
                    end
                    if (r_col > {1'b0, v_wc}) n_col = {1'b0, v_wc};
                    if (r_row > {9'd0, v_hc}) n_row = {9'd0, v_hc};
                end else if (i_char.valid) begin
                    n_char = i_char.char_code;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_state = ST_WRAP;
                v_e.back_rgb = r_colr.cur_back;
                if (r_phase == PH_TEXT) begin
                    if (v_c == ChEsc) n_phase = PH_ESC;
                    else if (v_c == ChTab) begin
                        v_tab = (r_col + 9'd4) & 9'h1FC;
                        if (v_tab >= {1'b0, w_w}) begin
                            n_col = '0;
                            n_row = r_row + 17'd1;
                        end else n_col = v_tab;
                    end else if (v_c == ChLf) begin
                        n_col = '0;
                        n_row = r_row + 17'd1;
                    end else if (v_c == ChCr) n_col = '0;
                    else if (v_c == ChBs) begin
                        if (r_col != 9'd0) n_col = r_col - 9'd1;
                    end else begin
                        v_e.kind = KindPut;
                        v_e.column = r_col[7:0];
                        v_e.row = r_row[7:0];
                        v_e.glyph = v_c;
                        v_e.fore_rgb = r_colr.cur_fore;
                        n_ev[0] = v_e;
                        n_nev = 2'd1;
                        n_col = r_col + 9'd1;
                    end
                end else if (r_phase == PH_ESC) begin
                    if (v_c == ChBracket) begin
                        n_phase = PH_CSI;
                        n_pidx = '0;
                        n_param[0] = '0;
                    end else n_phase = PH_TEXT;
                end else begin
                    if ({{(32-PiW){1'b0}}, r_pidx} >= MAX_PARAMS) v_pi = '0;
                    n_pidx = v_pi;
                    if (v_c >= ChZero && v_c <= ChNine) begin
                        v_acc = {r_param[v_pi], 3'd0} + {2'd0, r_param[v_pi], 1'b0}
                                + {4'd0, v_dig};
                        n_param[v_pi] = (v_acc > 20'd65535) ? 16'hFFFF : v_acc[15:0];
                    end else if (v_c == ChSemi &&
                                 ({{(32-PiW){1'b0}}, v_pi} + 1) < MAX_PARAMS) begin
                        n_pidx = v_pi + PiW'(1);
                        n_param[v_pi + PiW'(1)] = '0;
                    end else begin
                        n_phase = PH_TEXT;
                        case (v_c)
                            16'd72, 16'd102: begin
                                n_row = (v_p0 < {8'd0, v_hc}) ? {1'b0, v_p0} : {9'd0, v_hc};
                                if (v_pi != '0 && MAX_PARAMS > 1)
                                    n_col = (v_p1 < {8'd0, v_wc}) ? v_p1[8:0] : {1'b0, v_wc};
                            end
                            16'd65: if (r_row >= {1'b0, v_p0}) n_row = r_row - {1'b0, v_p0};
                            16'd66: n_row = r_row + {1'b0, v_p0};
                            16'd67: begin
                                // anything past the last column only has to reach the wrap
                                v_csum = {8'd0, r_col} + {1'b0, v_p0};
                                n_col = (v_csum >= {9'd0, w_w}) ? {1'b0, w_w} : v_csum[8:0];
                            end
                            16'd68: if ({7'd0, r_col} >= v_p0) n_col = r_col - v_p0[8:0];
                            16'd115: begin
                                n_scol = r_col[7:0];
                                n_srow = r_row[7:0];
                            end
                            16'd117: begin
                                n_col = {1'b0, r_scol};
                                n_row = {9'd0, r_srow};
                            end
                            16'd74: begin
                                v_e.kind = KindClear;
                                n_ev[0] = v_e;
                                n_nev = 2'd1;
                                n_col = '0;
                                n_row = '0;
                            end
                            16'd75: begin
                                v_e.kind = KindClearEol;
                                v_e.column = r_col[7:0];
                                v_e.row = r_row[7:0];
                                n_ev[0] = v_e;
                                n_nev = 2'd1;
                            end
                            16'd109: begin
                                n_sgr_i = '0;
                                n_sgr_n = v_pi;
                                n_state = ST_SGR;
                            end
                            16'd110: if (v_p0 == 16'd6) begin
                                v_e.kind = KindReport;
                                v_e.column = r_col[7:0];
                                v_e.row = r_row[7:0];
                                v_e.back_rgb = '0;
                                n_ev[0] = v_e;
                                n_nev = 2'd1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            ST_SGR: begin
                // one stored parameter per cycle through the colour unit
                n_colr = w_sgr_out;
                n_sgr_i = r_sgr_i + PiW'(1);
                if (r_sgr_i == r_sgr_n) n_state = ST_WRAP;
            end
            ST_WRAP: begin
                n_row = r_row;
                n_col = r_col;
                if (r_col >= {1'b0, w_w}) begin
                    n_col = '0;
                    n_row = r_row + 17'd1;
                end
                if (n_row > {9'd0, v_hc}) begin
                    v_lines = n_row - {9'd0, v_hc};
                    v_e.kind = KindScroll;
                    v_e.back_rgb = r_colr.cur_back;
                    v_e.scroll_lines = (v_lines > {9'd0, w_h}) ? w_h : v_lines[7:0];
                    n_ev[r_nev[0]] = v_e;
                    n_nev = r_nev + 2'd1;
                    n_row = {9'd0, v_hc};
                end
                n_state = (n_nev == 2'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (o_event.ready) begin
                    if (o_event.last) n_state = ST_IDLE;
                    else n_eidx = 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // row is no larger than the screen height when idle after a wrap
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && $past(r_state) == ST_WRAP) |-> r_row <= {9'd0, w_h})
        else $error("row beyond screen after wrap");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event.valid |-> (r_nev == 2'd1 || r_nev == 2'd2))
        else $error("result shown with empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_char.valid && i_char.ready) |=> !i_char.ready)
        else $error("second item taken while busy");
endmodule

// ----- rtl/core/atte_sgr_unit.sv -----
// one sgr step: applies one parameter to the colour set
module atte_sgr_unit (
    input  logic [15:0]        i_value,
    input  atte_pkg::t_colours i_col,
    output atte_pkg::t_colours o_col
);
    import atte_pkg::*;

    logic [15:0] w_off30;
    logic [15:0] w_off40;

    assign w_off30 = i_value - 16'd30;
    assign w_off40 = i_value - 16'd40;

    // apply code
    always_comb begin
        o_col = i_col;
        if (i_value == 16'd0) begin
            o_col.cur_fore = i_col.dflt_fore;
            o_col.cur_back = i_col.dflt_back;
        end else if (i_value == 16'd1) begin
            o_col.cur_fore = brighter(i_col.dflt_fore);
        end else if (i_value == 16'd5) begin
            o_col.cur_back = brighter(i_col.dflt_back);
        end else if (i_value == 16'd7) begin
            o_col.cur_fore = i_col.cur_back;
            o_col.cur_back = i_col.cur_fore;
        end else if (i_value == 16'd8) begin
            o_col.cur_fore = i_col.cur_back;
        end else if (w_off30 < 16'd8) begin
            o_col.cur_fore  = palette(w_off30[2:0]);
            o_col.dflt_fore = palette(w_off30[2:0]);
        end else if (w_off40 < 16'd8) begin
            o_col.cur_back  = palette(w_off40[2:0]);
            o_col.dflt_back = palette(w_off40[2:0]);
        end
    end
endmodule

// ----- sim/ansi_text_terminal_engine_tb.sv -----
// testbench for the ansi text terminal engine: directed table, then random text and escapes
`timescale 1ns / 100ps

module ansi_text_terminal_engine_tb;
    import atte_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int N_RANDOM = 1320;

    logic i_clk;
    logic i_rst_n;

    atte_char_if  char_ch ();
    atte_cfg_if   cfg_ch ();
    atte_event_if event_ch ();

    ansi_text_terminal_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_ch),
        .i_cfg   (cfg_ch),
        .o_event (event_ch)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // predictor state
    logic [7:0]  scr_cols, scr_rows;
    t_phase      prs_phase;
    int unsigned prs_idx;
    int unsigned prs_val [3];
    int unsigned cur_col, cur_row, sav_col, sav_row;
    logic [23:0] fg_now, bg_now, fg_dflt, bg_dflt;

    t_event      pending_events [$];
    int          fail_count;
    int          mismatch_count;
    int          events_seen;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          sent_items;

    // add one expected result
    function automatic void push_event(logic [2:0] k, int unsigned c, int unsigned r,
                                       logic [15:0] g, logic [23:0] f, logic [23:0] b,
                                       int unsigned n);
        t_event e;
        e.kind = k;
        e.column = c[7:0];
        e.row = r[7:0];
        e.glyph = g;
        e.fore_rgb = f;
        e.back_rgb = b;
        e.scroll_lines = n[7:0];
        e.last = 1'b0;
        pending_events.push_back(e);
    endfunction

    function automatic logic [23:0] lift_colour(logic [23:0] c);
        return {c[23] ? 8'hFF : 8'h80, c[15] ? 8'hFF : 8'h80, c[7] ? 8'hFF : 8'h80};
    endfunction

    function automatic logic [23:0] base_colour(int unsigned i);
        case (i)
            0: return 24'h000000;
            1: return 24'h800000;
            2: return 24'h008000;
            3: return 24'h808000;
            4: return 24'h000080;
            5: return 24'h800080;
            6: return 24'h008080;
            default: return 24'hC0C0C0;
        endcase
    endfunction

    function automatic int unsigned eff_w();
        return (scr_cols == 0) ? 1 : scr_cols;
    endfunction

    function automatic int unsigned eff_h();
        return (scr_rows == 0) ? 1 : scr_rows;
    endfunction

    function automatic void terminal_reset();
        scr_cols = ColumnsReset;
        scr_rows = RowsReset;
        prs_phase = PH_TEXT;
        prs_idx = 0;
        prs_val = '{0, 0, 0};
        cur_col = 0; cur_row = 0; sav_col = 0; sav_row = 0;
        fg_now = ForeReset; fg_dflt = ForeReset;
        bg_now = BackReset; bg_dflt = BackReset;
    endfunction

    function automatic void terminal_config(logic [0:0] idx, logic [7:0] val);
        if (idx == RegColumns) scr_cols = val;
        else scr_rows = val;
        if (cur_col > eff_w() - 1) cur_col = eff_w() - 1;
        if (cur_row > eff_h() - 1) cur_row = eff_h() - 1;
    endfunction

    // csi command
    function automatic void run_csi(logic [15:0] cmd, int unsigned cnt);
        int unsigned p0, w, h, v;
        logic [23:0] t;
        p0 = prs_val[0];
        w = eff_w();
        h = eff_h();
        case (cmd)
            16'd72, 16'd102: begin
                cur_row = (p0 < h - 1) ? p0 : h - 1;
                if (cnt > 1) begin
                    v = prs_val[1];
                    cur_col = (v < w - 1) ? v : w - 1;
                end
            end
            16'd65: if (cur_row >= p0) cur_row -= p0;
            16'd66: cur_row += p0;
            16'd67: cur_col += p0;
            16'd68: if (cur_col >= p0) cur_col -= p0;
            16'd115: begin
                sav_col = cur_col; sav_row = cur_row;
            end
            16'd117: begin
                cur_col = sav_col; cur_row = sav_row;
            end
            16'd74: begin
                push_event(KindClear, 0, 0, 0, 0, bg_now, 0);
                cur_col = 0; cur_row = 0;
            end
            16'd75: push_event(KindClearEol, cur_col, cur_row, 0, 0, bg_now, 0);
            16'd109: begin
                for (int i = 0; i < cnt && i < 3; i++) begin
                    v = prs_val[i];
                    if (v == 0) begin
                        fg_now = fg_dflt; bg_now = bg_dflt;
                    end else if (v == 1) fg_now = lift_colour(fg_dflt);
                    else if (v == 5) bg_now = lift_colour(bg_dflt);
                    else if (v == 7) begin
                        t = bg_now; bg_now = fg_now; fg_now = t;
                    end else if (v == 8) fg_now = bg_now;
                    else if (v >= 30 && v <= 37) begin
                        fg_now = base_colour(v - 30); fg_dflt = fg_now;
                    end else if (v >= 40 && v <= 47) begin
                        bg_now = base_colour(v - 40); bg_dflt = bg_now;
                    end
                end
            end
            16'd110: if (p0 == 6) push_event(KindReport, cur_col, cur_row, 0, 0, 0, 0);
            default: ;
        endcase
    endfunction

    // one character through the terminal; returns the number of results queued
    function automatic int terminal_step(logic [15:0] c);
        int unsigned w, h, n, v;
        int base;
        base = pending_events.size();
        w = eff_w();
        h = eff_h();
        if (prs_phase == PH_TEXT) begin
            if (c == ChEsc) prs_phase = PH_ESC;
            else if (c == ChTab) begin
                cur_col = (cur_col + 4) & ~32'd3;
                if (cur_col >= w) begin
                    cur_col = 0; cur_row++;
                end
            end else if (c == ChLf) begin
                cur_col = 0; cur_row++;
            end else if (c == ChCr) cur_col = 0;
            else if (c == ChBs) begin
                if (cur_col > 0) cur_col--;
            end else begin
                push_event(KindPut, cur_col, cur_row, c, fg_now, bg_now, 0);
                cur_col++;
            end
        end else if (prs_phase == PH_ESC) begin
            if (c == ChBracket) begin
                prs_phase = PH_CSI; prs_idx = 0; prs_val[0] = 0;
            end else prs_phase = PH_TEXT;
        end else begin
            if (prs_idx >= 3) prs_idx = 0;
            if (c >= ChZero && c <= ChNine) begin
                v = prs_val[prs_idx] * 10 + (c - ChZero);
                prs_val[prs_idx] = (v > 65535) ? 65535 : v;
            end else if (c == ChSemi && prs_idx + 1 < 3) begin
                prs_idx++;
                prs_val[prs_idx] = 0;
            end else begin
                prs_phase = PH_TEXT;
                run_csi(c, prs_idx + 1);
            end
        end
        if (cur_col >= w) begin
            cur_col = 0; cur_row++;
        end
        if (cur_row > h - 1) begin
            n = cur_row - (h - 1);
            if (n > h) n = h;
            push_event(KindScroll, 0, 0, 0, 0, bg_now, n);
            cur_row = h - 1;
        end
        if (pending_events.size() > base)
            pending_events[pending_events.size() - 1].last = 1'b1;
        return pending_events.size() - base;
    endfunction

    // send one character and queue its results
    task automatic send_char(logic [15:0] c);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            char_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.char_code <= c;
        @(posedge i_clk);
        while (!char_ch.ready) @(posedge i_clk);
        void'(terminal_step(c));
        sent_items++;
        // the block is busy in the cycle after an item, so dropping valid costs nothing
        char_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(16'(s[i]));
    endtask

    // wait until every result is in, then let the sequencer settle
    task automatic drain();
        while (pending_events.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [7:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        terminal_config(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver: ready with random stalls, compare each result
    always @(posedge i_clk) begin
        t_event got, want;
        if (!i_rst_n) begin
            event_ch.ready <= 1'b0;
        end else begin
            if (event_ch.valid && event_ch.ready) begin
                got = {event_ch.kind, event_ch.column, event_ch.row, event_ch.glyph,
                       event_ch.fore_rgb, event_ch.back_rgb, event_ch.scroll_lines,
                       event_ch.last};
                events_seen++;
                if (pending_events.size() == 0) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %h", got);
                end else begin
                    want = pending_events.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected %h got %h", want, got);
                    end
                end
            end
            event_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL ansi_text_terminal_engine");
            $finish;
        end
    end

    // directed rows: character and, where obvious, the expected single result
    typedef struct {
        logic [15:0] code;
        logic        known;
        t_event      want;
    } t_row;

    t_row dir_rows [$];

    function automatic void add_row(logic [15:0] c);
        t_row r;
        r.code = c;
        r.known = 1'b0;
        r.want = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_known(logic [15:0] c, t_event e);
        t_row r;
        r.code = c;
        r.known = 1'b1;
        r.want = e;
        dir_rows.push_back(r);
    endfunction

    // random escape sequence with random content
    task automatic send_random_escape();
        int np;
        logic [15:0] cmds [13];
        cmds = '{16'd72, 16'd102, 16'd65, 16'd66, 16'd67, 16'd68, 16'd115, 16'd117,
                 16'd74, 16'd75, 16'd109, 16'd110, 16'd122};
        send_char(ChEsc);
        if ($urandom_range(15) == 0) begin
            send_char(16'($urandom_range(65535)));
            return;
        end
        send_char(ChBracket);
        np = $urandom_range(4);
        for (int p = 0; p < np; p++) begin
            case ($urandom_range(5))
                0: ;
                1: send_char(16'(ChZero + $urandom_range(9)));
                2: send_text($sformatf("%0d", $urandom_range(47)));
                3: send_text($sformatf("%0d", 30 + $urandom_range(17)));
                4: send_text($sformatf("%0d", $urandom_range(300)));
                default: send_text("999999");
            endcase
            if (p < np - 1) send_char(ChSemi);
        end
        if ($urandom_range(9) == 0) send_char(16'($urandom_range(65535)));
        else send_char(cmds[$urandom_range(12)]);
    endtask

    task automatic send_random_text();
        case ($urandom_range(9))
            0: send_char(ChTab);
            1: send_char(ChLf);
            2: send_char(ChCr);
            3: send_char(ChBs);
            4: send_char(16'($urandom_range(65535)));
            5: send_char(16'($urandom_range(31)));
            default: send_char(16'(32 + $urandom_range(94)));
        endcase
    endtask

    initial begin
        logic [7:0] col_set [6];
        logic [7:0] row_set [6];
        t_event e;
        int phase_start;
        col_set = '{8'd255, 8'd1, 8'd7, 8'd0, 8'd16, 8'd80};
        row_set = '{8'd255, 8'd1, 8'd3, 8'd0, 8'd5, 8'd25};

        cycle_count = 0;
        fail_count = 0;
        mismatch_count = 0;
        events_seen = 0;
        sent_items = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        char_ch.valid = 1'b0;
        char_ch.char_code = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = RegColumns;
        cfg_ch.data = '0;
        terminal_reset();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: reset state, extremes and each control and command
        e = '{KindPut, 8'd0, 8'd0, 16'h0041, ForeReset, BackReset, 8'd0, 1'b1};
        add_known(16'h0041, e);
        e = '{KindPut, 8'd1, 8'd0, 16'hFFFF, ForeReset, BackReset, 8'd0, 1'b1};
        add_known(16'hFFFF, e);
        add_row(16'h0000);
        add_row(ChTab); add_row(ChBs); add_row(ChCr); add_row(ChLf);
        add_row(ChEsc); add_row(16'd120);
        add_row(ChEsc); add_row(ChBracket); add_row(16'd54); add_row(16'd110);
        add_row(ChEsc); add_row(ChBracket); add_row(16'd51); add_row(16'd49);
        add_row(ChSemi); add_row(16'd49); add_row(ChSemi); add_row(16'd55);
        add_row(ChSemi); add_row(16'd109);
        add_row(ChEsc); add_row(ChBracket); add_row(16'd74);
        for (int i = 0; i < dir_rows.size(); i++) begin
            if (dir_rows[i].known) begin
                drain();
                void'(terminal_step(dir_rows[i].code));
                pending_events.pop_back();
                pending_events.push_back(dir_rows[i].want);
                // replay only the handshake: the prediction is already queued
                char_ch.valid <= 1'b1;
                char_ch.char_code <= dir_rows[i].code;
                @(posedge i_clk);
                while (!char_ch.ready) @(posedge i_clk);
                sent_items++;
                char_ch.valid <= 1'b0;
                @(posedge i_clk);
            end else begin
                send_char(dir_rows[i].code);
            end
        end
        send_text("\033[99999999;70000H\033[K\033[A\033[s\033[1;5;8m\033[u\033[fZ");
        send_text("\033[5C\033[9D\033[B\033[0;40;37m\033[m\033[q");
        drain();

        // random phases over screen sizes and idling patterns
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(RegColumns, col_set[ph]);
            write_reg(RegRows, row_set[ph]);
            if (ph < 2) begin
                send_idle_pct = 31; recv_idle_pct = 73;
            end else if (ph < 4) begin
                send_idle_pct = 73; recv_idle_pct = 31;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            phase_start = sent_items;
            while (sent_items < phase_start + N_RANDOM / 6) begin
                if ($urandom_range(2) == 0) send_random_escape();
                else send_random_text();
            end
            drain();
        end

        $display("covered directed controls and escapes, then random text and csi commands");
        $display("over six screen sizes; %0d items sent, %0d results checked, %0d failures",
                 sent_items, events_seen, fail_count);
        if (fail_count == 0 && pending_events.size() == 0) begin
            $display("PASS ansi_text_terminal_engine");
        end else begin
            $display("FAIL ansi_text_terminal_engine");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/atte_pkg.sv
rtl/core/atte_if.sv
rtl/core/atte_sgr_unit.sv
rtl/core/ansi_text_terminal_engine.sv
sim/ansi_text_terminal_engine_tb.sv
